[rtl/grs_pkg.sv]
// Shared types and register indexes for the gain rider smoother.
package grs_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_ATTACK_COEFF      = 3'd0;
   localparam logic [2:0] CSR_RELEASE_COEFF     = 3'd1;
   localparam logic [2:0] CSR_HOLD_LENGTH       = 3'd2;
   localparam logic [2:0] CSR_SILENCE_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_TARGET_LEVEL      = 3'd4;
   localparam logic [2:0] CSR_GAIN_RANGE        = 3'd5;

   localparam int unsigned CSR_DATA_W = 20;

   typedef struct packed {
      logic        [15:0] attack_coeff;
      logic        [15:0] release_coeff;
      logic        [19:0] hold_length;
      logic signed [15:0] silence_threshold;
      logic signed [15:0] target_level;
      logic        [14:0] gain_range;
   } cfg_type;

   // Word held between the target stage and the smoother
   typedef struct packed {
      logic               valid;
      logic signed [15:0] want;
   } stage_type;

endpackage

[rtl/grs_csr.sv]
// Configuration registers of the gain rider smoother.
module grs_csr import grs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_ATTACK_COEFF:      cfg_in.attack_coeff      = csr_wdata[15:0];
            CSR_RELEASE_COEFF:     cfg_in.release_coeff     = csr_wdata[15:0];
            CSR_HOLD_LENGTH:       cfg_in.hold_length       = csr_wdata[19:0];
            CSR_SILENCE_THRESHOLD: cfg_in.silence_threshold = $signed(csr_wdata[15:0]);
            CSR_TARGET_LEVEL:      cfg_in.target_level      = $signed(csr_wdata[15:0]);
            CSR_GAIN_RANGE:        cfg_in.gain_range        = csr_wdata[14:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coeff      <= 16'd65399;
         cfg_ff.release_coeff     <= 16'd65522;
         cfg_ff.hold_length       <= 20'd0;
         cfg_ff.silence_threshold <= -16'sd15360;
         cfg_ff.target_level      <= -16'sd4608;
         cfg_ff.gain_range        <= 15'd3072;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/grs_target.sv]
// Wanted-gain stage: silence gate and clamped target minus level.
module grs_target import grs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               load,
   input  logic               advance,
   input  logic signed [15:0] level_db,
   output stage_type          stage
);

   logic               valid_ff;
   logic               valid_in;
   logic signed [15:0] want_ff;
   logic signed [15:0] want_in;
   logic signed [16:0] need;
   logic signed [16:0] range_pos;
   logic signed [16:0] range_neg;

   always_comb begin
      need      = 17'(cfg.target_level) - 17'(level_db);
      range_pos = $signed({2'b00, cfg.gain_range});
      range_neg = -range_pos;
      priority if (level_db < cfg.silence_threshold) begin
         want_in = '0;
      end else if (need > range_pos) begin
         want_in = range_pos[15:0];
      end else if (need < range_neg) begin
         want_in = range_neg[15:0];
      end else begin
         want_in = need[15:0];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         want_ff <= want_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.want  = want_ff;

endmodule

[rtl/grs_smoother.sv]
// Hold logic, one-pole smoother and result register.
module grs_smoother import grs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  stage_type          stage,
   input  logic               advance,
   output logic               out_valid,
   output logic signed [15:0] gain_db,
   output logic               holding
);

   logic signed [15:0] smooth_ff, smooth_in;
   logic signed [15:0] last_ff, last_in;
   logic        [19:0] count_ff, count_in;
   logic               valid_ff;
   logic signed [15:0] gain_ff;
   logic               held_ff, held_in;
   logic               fire;
   logic signed [15:0] tgt;
   logic        [15:0] coeff;
   logic signed [16:0] diff;
   logic        [15:0] dmag;
   logic        [31:0] prod;
   logic        [15:0] mag;
   logic signed [16:0] err;
   logic signed [16:0] sum;

   assign fire = stage.valid & advance;

   // hold: keep the previous target for up to hold_length words while the wanted gain is below it
   always_comb begin
      tgt      = stage.want;
      held_in  = 1'b0;
      last_in  = last_ff;
      count_in = count_ff;
      if (cfg.hold_length != '0) begin
         if (stage.want < last_ff) begin
            if (count_ff < cfg.hold_length) begin
               count_in = count_ff + 20'd1;
               tgt      = last_ff;
               held_in  = 1'b1;
            end else begin
               last_in  = stage.want;
               count_in = '0;
            end
         end else begin
            last_in  = stage.want;
            count_in = '0;
         end
      end else begin
         last_in = stage.want;
      end
   end

   // target + c*(smoothed - target), magnitude truncated, snap within one LSB
   always_comb begin
      coeff = (tgt > smooth_ff) ? cfg.attack_coeff : cfg.release_coeff;
      diff  = 17'(smooth_ff) - 17'(tgt);
      dmag  = diff[16] ? 16'(-diff) : diff[15:0];
      prod  = dmag * coeff;
      mag   = prod[31:16];
      if (mag <= 16'd1) begin
         err = '0;
      end else if (diff[16]) begin
         err = -$signed({1'b0, mag});
      end else begin
         err = $signed({1'b0, mag});
      end
      sum       = 17'(tgt) + err;
      smooth_in = sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         last_ff   <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= stage.valid;
         end
         if (fire) begin
            smooth_ff <= smooth_in;
            last_ff   <= last_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         gain_ff <= smooth_in;
         held_ff <= held_in;
      end
   end

   assign out_valid = valid_ff;
   assign gain_db   = gain_ff;
   assign holding   = held_ff;

endmodule

[rtl/gain_rider_smoother_unit.sv]
// Top level of the gain rider smoother: attack/release smoother with hold.
//
//  channel   dir  fields (lowest bit up)
//  req_      in   tdata: level_db[15:0]
//  rsp_      out  tdata: gain_db[15:0]; tuser: holding
//  csr_      in   we, addr[2:0], wdata[19:0]
//
// One word per cycle while rsp is not stalled; rsp_tvalid rises once an accepted req word
// has passed the wanted-gain register, then the smoother and result register.
// The smoother's 16x16 multiply sits in the smoothed-gain state loop.
// Synchronous reset clears the smoother state and valid flags, not the data registers.
// rsp stalls back up into the wanted-gain stage; req_tready stays high
// while that stage is empty or moving on.
module gain_rider_smoother_unit import grs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // level_db[15:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // gain_db[15:0]
   output logic [0:0]            rsp_tuser,   // holding
   input  logic                  csr_we,
   input  logic [2:0]            csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg;
   stage_type          stage;
   logic               advance;
   logic               load;
   logic signed [15:0] gain_db;
   logic               holding;

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = ~stage.valid | advance;
   assign load       = req_tvalid & req_tready;

   grs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   grs_target u_target (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .load     (load),
      .advance  (advance),
      .level_db ($signed(req_tdata)),
      .stage    (stage)
   );

   grs_smoother u_smoother (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .stage     (stage),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .gain_db   (gain_db),
      .holding   (holding)
   );

   assign rsp_tdata    = gain_db;
   assign rsp_tuser[0] = holding;

   a_load_fills_stage: assert property (@(posedge clock) disable iff (reset)
      load |=> stage.valid)
      else $error("accepted word did not reach the target stage");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("req accepted while pipeline full and stalled");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !stage.valid) |=> !rsp_tvalid)
      else $error("result repeated after drain");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && advance) |=> rsp_tvalid)
      else $error("stage word lost on the way to rsp");

endmodule
